FILE: rtl/core/stack_with_max_sum_count_core_macros.svh
// assertion helpers for the stack core checker
`ifndef STACK_WITH_MAX_SUM_COUNT_CORE_MACROS_SVH
`define STACK_WITH_MAX_SUM_COUNT_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define SMSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define SMSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/smsc_pkg.sv
`timescale 1ns / 1ps

package smsc_pkg;

    // fixed field widths
    localparam int VAL_W = 32;
    localparam int TOT_W = 36;
    localparam int CNT_W = 5;
    localparam int CMD_W = 2;
    localparam int ST_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DUMP_RD,
        S_DUMP_CAP,
        S_EMIT
    } t_state;

    // control of the shared max unit
    typedef struct packed {
        logic clr;
        logic load;
        logic upd;
    } t_max_ctl;

endpackage

FILE: rtl/core/smsc_in_if.sv
`timescale 1ns / 1ps

interface smsc_in_if;
    logic                                valid;
    logic                                ready;
    logic [smsc_pkg::CMD_W-1:0]          cmd;
    logic signed [smsc_pkg::VAL_W-1:0]   push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

FILE: rtl/core/smsc_out_if.sv
`timescale 1ns / 1ps

interface smsc_out_if;
    logic                                valid;
    logic                                ready;
    logic [smsc_pkg::ST_W-1:0]           status;
    logic signed [smsc_pkg::VAL_W-1:0]   value;
    logic                                last;
    logic [smsc_pkg::CNT_W-1:0]          count;
    logic signed [smsc_pkg::TOT_W-1:0]   total;
    logic signed [smsc_pkg::VAL_W-1:0]   largest;

    modport source (output valid, output status, output value, output last,
                    output count, output total, output largest, input ready);
    modport sink   (input valid, input status, input value, input last,
                    input count, input total, input largest, output ready);
endinterface

FILE: rtl/core/smsc_ram.sv
`timescale 1ns / 1ps

module smsc_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [smsc_pkg::VAL_W-1:0] i_wdata,
    input  logic [AW-1:0]                     i_raddr,
    output logic signed [smsc_pkg::VAL_W-1:0] o_rdata
);
    import smsc_pkg::*;

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/smsc_max.sv
`timescale 1ns / 1ps

module smsc_max (
    input  logic                              i_clk,
    input  smsc_pkg::t_max_ctl                i_ctl,
    input  logic signed [smsc_pkg::VAL_W-1:0] i_data,
    output logic signed [smsc_pkg::VAL_W-1:0] o_best
);
    import smsc_pkg::*;

    logic signed [VAL_W-1:0] r_best;

    // running maximum, one signed compare per step
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.clr) begin
            r_best <= '0;
        end else if (i_ctl.load) begin
            r_best <= i_data;
        end else if (i_ctl.upd && (i_data > r_best)) begin
            r_best <= i_data;
        end
    end

    assign o_best = r_best;

endmodule

FILE: rtl/core/stack_with_max_sum_count_core.sv
`timescale 1ns / 1ps

// Bounded LIFO stack of signed 32-bit values, DEPTH entries deep. Each input beat is a
// push, a pop or a dump; every output beat carries the status, the popped or dumped
// value, the element count, the exact 36-bit sum and the largest stored element (0 when
// empty), all after the operation. The store is a single-port-read memory and the
// maximum is rebuilt after every command by walking the stored entries through one
// shared compare unit, with a read state and a compare state per entry. A pop first
// reads the top entry; a dump then walks its beats top down, each through a read, a
// capture and an emit state; an empty pop or dump goes straight to the emit state. The
// next input beat is taken once the last output beat sits in the output register.
module stack_with_max_sum_count_core #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smsc_in_if.sink    i_in,
    smsc_out_if.source o_out
);
    import smsc_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [FW-1:0] FULL_CNT = FW'(DEPTH);

    t_state                  r_state, n_state;
    logic [FW-1:0]           r_fill, n_fill;
    logic signed [TOT_W-1:0] r_total, n_total;
    logic [AW-1:0]           r_idx, n_idx;
    logic                    r_dump, n_dump;
    logic [ST_W-1:0]         r_status, n_status;
    logic signed [VAL_W-1:0] r_value, n_value;
    logic                    r_last, n_last;
    logic                    r_ov, n_ov;

    logic [ST_W-1:0]         r_ostatus;
    logic signed [VAL_W-1:0] r_ovalue;
    logic                    r_olast;
    logic [CNT_W-1:0]        r_ocount;
    logic signed [TOT_W-1:0] r_ototal;
    logic signed [VAL_W-1:0] r_olargest;

    logic                    in_rdy;
    logic                    out_free;
    logic                    out_load;
    logic [FW-1:0]           fill_m1;
    logic                    idx_at_top;
    logic                    we;
    logic [AW-1:0]           rd_addr;
    logic signed [VAL_W-1:0] rdata;
    logic signed [TOT_W-1:0] rdata_ext;
    logic signed [TOT_W-1:0] push_ext;
    t_max_ctl                max_ctl;
    logic signed [VAL_W-1:0] best;

    // element store
    smsc_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_in.push_value),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // shared compare unit for the maximum
    smsc_max u_max (
        .i_clk  (i_clk),
        .i_ctl  (max_ctl),
        .i_data (rdata),
        .o_best (best)
    );

    assign out_free   = !r_ov || o_out.ready;
    assign fill_m1    = r_fill - 1'b1;
    assign idx_at_top = (FW'(r_idx) == fill_m1);
    assign rdata_ext  = {{(TOT_W - VAL_W){rdata[VAL_W-1]}}, rdata};
    assign push_ext   = {{(TOT_W - VAL_W){i_in.push_value[VAL_W-1]}}, i_in.push_value};

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_total  = r_total;
        n_idx    = r_idx;
        n_dump   = r_dump;
        n_status = r_status;
        n_value  = r_value;
        n_last   = r_last;
        n_ov     = r_ov && !o_out.ready;
        in_rdy   = 1'b0;
        we       = 1'b0;
        rd_addr  = r_idx;
        max_ctl  = '0;
        out_load = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                in_rdy = 1'b1;
                if (i_in.valid) begin
                    max_ctl.clr = 1'b1;
                    n_value     = '0;
                    n_last      = 1'b1;
                    n_status    = ST_OK;
                    n_idx       = '0;
                    n_dump      = 1'b0;
                    unique case (i_in.cmd)
                        CMD_PUSH: begin
                            if (r_fill == FULL_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_fill  = r_fill + 1'b1;
                                n_total = r_total + push_ext;
                            end
                            n_state = S_SCAN_RD;
                        end
                        CMD_POP: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_EMIT;
                            end else begin
                                n_fill  = fill_m1;
                                rd_addr = fill_m1[AW-1:0];
                                n_state = S_POP_RD;
                            end
                        end
                        CMD_DUMP: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_EMIT;
                            end else begin
                                n_dump  = 1'b1;
                                n_state = S_SCAN_RD;
                            end
                        end
                        default: begin
                            n_state = (r_fill == '0) ? S_EMIT : S_SCAN_RD;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                n_value = rdata;
                n_total = r_total - rdata_ext;
                n_state = (r_fill == '0) ? S_EMIT : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                max_ctl.load = (r_idx == '0);
                max_ctl.upd  = (r_idx != '0);
                if (idx_at_top) begin
                    if (r_dump) begin
                        n_idx   = fill_m1[AW-1:0];
                        n_state = S_DUMP_RD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_DUMP_RD: begin
                n_state = S_DUMP_CAP;
            end
            S_DUMP_CAP: begin
                n_value = rdata;
                n_last  = (r_idx == '0);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_ov     = 1'b1;
                    if (r_dump && !r_last) begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_DUMP_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_total <= '0;
            r_dump  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_total <= n_total;
            r_dump  <= n_dump;
            r_ov    <= n_ov;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ostatus  <= r_status;
            r_ovalue   <= r_value;
            r_olast    <= r_last;
            r_ocount   <= CNT_W'(r_fill);
            r_ototal   <= r_total;
            r_olargest <= best;
        end
    end

    assign i_in.ready    = in_rdy;
    assign o_out.valid   = r_ov;
    assign o_out.status  = r_ostatus;
    assign o_out.value   = r_ovalue;
    assign o_out.last    = r_olast;
    assign o_out.count   = r_ocount;
    assign o_out.total   = r_ototal;
    assign o_out.largest = r_olargest;

endmodule

FILE: rtl/core/smsc_chk.sv
`timescale 1ns / 1ps

`include "stack_with_max_sum_count_core_macros.svh"

module smsc_chk #(
    parameter int DEPTH = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [smsc_pkg::ST_W-1:0]         i_status,
    input logic signed [smsc_pkg::VAL_W-1:0] i_value,
    input logic                              i_last,
    input logic [smsc_pkg::CNT_W-1:0]        i_count,
    input logic signed [smsc_pkg::TOT_W-1:0] i_total,
    input logic signed [smsc_pkg::VAL_W-1:0] i_largest
);
    import smsc_pkg::*;

    localparam int PW = ST_W + 1 + CNT_W + TOT_W + 2 * VAL_W;

    logic          stall;
    logic          held;
    logic [PW-1:0] payload;
    logic [PW-1:0] r_payload;
    logic          empty_beat;
    logic          empty_ok;
    logic          full_beat;
    logic          inner_beat;
    logic          count_ok;

    // stalled beat keeps its payload
    assign stall   = i_out_valid && !i_out_ready;
    assign payload = {i_status, i_value, i_last, i_count, i_total, i_largest};

    // payload registered from the previous cycle
    always_ff @(posedge i_clk) begin
        r_payload <= payload;
    end

    assign held = i_out_valid && (payload == r_payload);

    // empty refusal reports an empty stack
    assign empty_beat = i_out_valid && (i_status == ST_EMPTY);
    assign empty_ok   = (i_value == '0) && (i_largest == '0) && i_last
                        && (i_count == '0) && (i_total == '0);

    // full refusal and count bound
    assign full_beat = i_out_valid && (i_status == ST_FULL);
    assign count_ok  = (DEPTH > 31) || (i_count <= CNT_W'(DEPTH));

    // only dump beats come before the last one
    assign inner_beat = i_out_valid && !i_last;

    `SMSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stall, held, "stalled beat changed")
    `SMSC_ASSERT_IMPL(a_empty, i_clk, i_rst_n, empty_beat, empty_ok, "bad empty beat")
    `SMSC_ASSERT_IMPL(a_full, i_clk, i_rst_n, full_beat, i_count == CNT_W'(DEPTH), "bad full beat")
    `SMSC_ASSERT_IMPL(a_inner, i_clk, i_rst_n, inner_beat, i_status == ST_OK, "bad dump beat")
    `SMSC_ASSERT_IMPL(a_count, i_clk, i_rst_n, i_out_valid, count_ok, "count above depth")

endmodule

bind stack_with_max_sum_count_core smsc_chk #(
    .DEPTH (DEPTH)
) u_smsc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_value     (o_out.value),
    .i_last      (o_out.last),
    .i_count     (o_out.count),
    .i_total     (o_out.total),
    .i_largest   (o_out.largest)
);
